// ===== rtl/core/cvg_pkg.sv =====
// ----------------------------------------------------------------------------
// Chiptune voice generator package
// Shared constants, configuration and job types for the voice generator.
// ----------------------------------------------------------------------------
package cvg_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned SineTableDepthDefault = 64;
  localparam int unsigned PhaseBitsDefault      = 32;

  // Decoupling queue between front and back
  localparam int unsigned QueueDepth = 2;

  // Configuration port
  localparam int unsigned CfgIdxWidth  = 2;
  localparam int unsigned CfgDataWidth = 24;

  localparam logic [CfgIdxWidth-1:0] CfgWaveShape = 2'd0;
  localparam logic [CfgIdxWidth-1:0] CfgDuty      = 2'd1;
  localparam logic [CfgIdxWidth-1:0] CfgDecay     = 2'd2;

  // Reset values
  localparam logic [15:0] DutyReset = 16'h8000;
  localparam logic [15:0] LfsrSeed  = 16'hACE1;

  // Mid-scale output used for silence
  localparam logic [7:0] SilentSample = 8'd127;

  typedef enum logic [1:0] {
    WAVE_SQUARE,
    WAVE_TRIANGLE,
    WAVE_SINE,
    WAVE_NOISE
  } wave_shape_e;

  typedef struct packed {
    wave_shape_e shape;
    logic [15:0] duty;
    logic [23:0] decay;
  } cfg_t;

  // One sample's worth of work handed from front to back
  typedef struct packed {
    logic        silent;
    logic [31:0] phase;      // phase left-aligned to 32 bits
    logic [23:0] volume;     // 8.16 volume used for this sample
    logic [15:0] noise_raw;  // held LFSR value, reduced mod 2000 in the back
  } job_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic full;
    logic empty;
  } queue_status_t;

endpackage

// ===== rtl/core/cvg_stream_if.sv =====
// ----------------------------------------------------------------------------
// Voice generator stream interfaces
// Valid/ready channels for note/tick beats in and audio sample beats out.
// ----------------------------------------------------------------------------
interface cvg_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [31:0] phase_step;
  logic [7:0]  start_volume;
  logic [15:0] noise_period;

  modport source (output valid, mode, phase_step, start_volume, noise_period, input ready);
  modport sink   (input valid, mode, phase_step, start_volume, noise_period, output ready);
endinterface

interface cvg_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] sample;
  logic [7:0] envelope_level;

  modport source (output valid, sample, envelope_level, input ready);
  modport sink   (input valid, sample, envelope_level, output ready);
endinterface

// ===== rtl/core/cvg_front.sv =====
// ----------------------------------------------------------------------------
// Voice generator front end
// Accepts beats, applies note starts, and advances phase, envelope and noise
// state; pushes one job per beat into the queue.
// ----------------------------------------------------------------------------
module cvg_front #(
  parameter int unsigned PHASE_BITS = cvg_pkg::PhaseBitsDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  cvg_in_if.sink        in_i,
  input  cvg_pkg::cfg_t cfg_i,
  input  logic          q_ready_i,
  output logic          push_o,
  output cvg_pkg::job_t job_o
);
  import cvg_pkg::*;

  localparam int unsigned PhaseShift = 32 - PHASE_BITS;

  logic [PHASE_BITS-1:0] acc_q, acc_d, acc_eff;
  logic [PHASE_BITS-1:0] inc_q, inc_d, inc_eff;
  logic [23:0]           vol_q, vol_d, vol_eff;
  logic [15:0]           cnt_q, cnt_d, cnt_eff;
  logic [15:0]           hold_q, hold_d, hold_eff;
  logic [15:0]           raw_q, raw_d;
  logic [15:0]           lfsr_q, lfsr_d, lfsr_next;
  logic                  silent_q, silent_d, silent_eff;
  logic [16:0]           cnt_inc;
  logic                  accept;

  assign in_i.ready = q_ready_i;
  assign accept     = in_i.valid && q_ready_i;
  assign push_o     = accept;

  // State as seen by this beat: a note start overrides it
  always_comb begin
    acc_eff    = acc_q;
    inc_eff    = inc_q;
    vol_eff    = vol_q;
    cnt_eff    = cnt_q;
    hold_eff   = hold_q;
    silent_eff = silent_q;
    if (in_i.mode) begin
      acc_eff    = '0;
      inc_eff    = in_i.phase_step[31 -: PHASE_BITS];
      vol_eff    = {in_i.start_volume, 16'h0000};
      cnt_eff    = '0;
      hold_eff   = (in_i.noise_period == 16'd0) ? 16'd1 : in_i.noise_period;
      silent_eff = (in_i.phase_step == 32'd0) || (in_i.start_volume == 8'd0);
    end
  end

  // x^16+x^14+x^13+x^11, shifting right
  assign lfsr_next = {lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5], lfsr_q[15:1]};
  assign cnt_inc   = {1'b0, cnt_eff} + 17'd1;

  // Next state
  always_comb begin
    acc_d    = acc_q;
    inc_d    = inc_q;
    vol_d    = vol_q;
    cnt_d    = cnt_q;
    hold_d   = hold_q;
    raw_d    = raw_q;
    lfsr_d   = lfsr_q;
    silent_d = silent_q;
    if (accept) begin
      acc_d    = acc_eff;
      inc_d    = inc_eff;
      vol_d    = vol_eff;
      cnt_d    = cnt_eff;
      hold_d   = hold_eff;
      silent_d = silent_eff;
      if (!silent_eff) begin
        if (cnt_eff == 16'd0) begin
          lfsr_d = lfsr_next;
          raw_d  = lfsr_next;
        end
        cnt_d = (cnt_inc >= {1'b0, hold_eff}) ? 16'd0 : cnt_inc[15:0];
        acc_d = acc_eff + inc_eff;
        vol_d = (vol_eff > cfg_i.decay) ? (vol_eff - cfg_i.decay) : 24'd0;
      end
    end
  end

  // Job for this beat
  always_comb begin
    job_o.silent    = silent_eff;
    job_o.phase     = 32'(acc_eff) << PhaseShift;
    job_o.volume    = vol_eff;
    job_o.noise_raw = (cnt_eff == 16'd0) ? lfsr_next : raw_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q    <= '0;
      inc_q    <= '0;
      vol_q    <= '0;
      cnt_q    <= '0;
      hold_q   <= 16'd1;
      raw_q    <= '0;
      lfsr_q   <= LfsrSeed;
      silent_q <= 1'b1;
    end else begin
      acc_q    <= acc_d;
      inc_q    <= inc_d;
      vol_q    <= vol_d;
      cnt_q    <= cnt_d;
      hold_q   <= hold_d;
      raw_q    <= raw_d;
      lfsr_q   <= lfsr_d;
      silent_q <= silent_d;
    end
  end

endmodule

// ===== rtl/core/cvg_queue.sv =====
// ----------------------------------------------------------------------------
// Voice generator job queue
// Short FIFO that decouples the front end from the sample pipeline.
// ----------------------------------------------------------------------------
module cvg_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  cvg_pkg::job_t          job_i,
  input  logic                   pop_i,
  output cvg_pkg::job_t          job_o,
  output logic                   valid_o,
  output logic                   ready_o,
  output cvg_pkg::queue_status_t status_o
);
  import cvg_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  job_t            entry_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            full, empty, do_push, do_pop;

  assign full    = (count_q == CntW'(QueueDepth));
  assign empty   = (count_q == '0);
  assign do_push = push_i && !full;
  assign do_pop  = pop_i && !empty;

  assign job_o   = entry_q[rd_ptr_q];
  assign valid_o = !empty;
  assign ready_o = !full;

  assign status_o.push  = push_i;
  assign status_o.pop   = pop_i;
  assign status_o.full  = full;
  assign status_o.empty = empty;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

// ===== rtl/core/cvg_back.sv =====
// ----------------------------------------------------------------------------
// Voice generator sample pipeline
// Turns queued jobs into samples: wave lookup, noise reduction, volume
// multiply, offset and scale, with a registered output beat.
// ----------------------------------------------------------------------------
module cvg_back #(
  parameter int unsigned SINE_TABLE_DEPTH = cvg_pkg::SineTableDepthDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cvg_pkg::cfg_t cfg_i,
  input  cvg_pkg::job_t job_i,
  input  logic          job_valid_i,
  output logic          pop_o,
  cvg_out_if.source     out_o
);
  import cvg_pkg::*;

  localparam int unsigned AddrW  = $clog2(SINE_TABLE_DEPTH);
  localparam int unsigned DepthW = $clog2(SINE_TABLE_DEPTH + 1);

  localparam logic [63:0] HalfPiQ30 = 64'd1686629713;
  localparam logic [63:0] SeriesDiv [7] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                            64'd110, 64'd156, 64'd210};

  // floor(x/2000) estimates: never high, at most one low
  localparam logic [15:0] NoiseRecip = 16'd33554;   // 2^26 / 2000
  localparam logic [19:0] LevelRecip = 20'd536870;  // 2^30 / 2000

  localparam logic signed [42:0] ToneOffset  = 43'sd1095216660480; // 255 * 2^32
  localparam logic signed [42:0] NoiseOffset = 43'sd16711680000;   // 255000 * 2^16

  // Quarter-wave sine entry by a fixed-point Taylor series
  function automatic logic [15:0] quarter_sine(input int unsigned k);
    logic [63:0] th;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] r;
    th   = (HalfPiQ30 * 64'(k)) / 64'(SINE_TABLE_DEPTH);
    term = th;
    sum  = th;
    for (int n = 1; n <= 7; n++) begin
      term = (term * th) >> 30;
      term = (term * th) >> 30;
      term = term / SeriesDiv[n-1];
      if (n % 2 == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    r = (sum + 64'd8192) >> 14;
    return (r > 64'd65535) ? 16'hFFFF : r[15:0];
  endfunction

  logic [15:0] sine_rom [SINE_TABLE_DEPTH];

  for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_rom
    localparam logic [15:0] Entry = quarter_sine(k);
    assign sine_rom[k] = Entry;
  end

  logic is_noise;
  logic adv;

  assign is_noise = (cfg_i.shape == WAVE_NOISE);

  // Whole pipeline moves when the output slot is free or being taken
  logic       out_valid_q;
  logic [7:0] out_sample_q, out_sample_d;
  logic [7:0] out_level_q, out_level_d;

  assign adv   = !out_valid_q || out_o.ready;
  assign pop_o = adv && job_valid_i;

  // ---------------- stage 1: wave value, noise quotient estimate
  logic [31:0]             ph;
  logic [32:0]             tri_dist;
  logic signed [18:0]      tri_wave;
  logic [30+DepthW-1:0]    pos_scaled;
  logic [DepthW-1:0]       sin_idx, sin_mir;
  logic [16:0]             sin_mag;
  logic signed [17:0]      wave;
  logic [31:0]             raw_scaled;

  assign ph = job_i.phase;

  always_comb begin
    tri_dist   = ph[31] ? (33'h1_0000_0000 - {1'b0, ph}) : {1'b0, ph};
    tri_wave   = $signed({1'b0, tri_dist[31:14]}) - 19'sd65536;
    pos_scaled = (30+DepthW)'(ph[29:0]) * (30+DepthW)'(SINE_TABLE_DEPTH);
    sin_idx    = pos_scaled[30 +: DepthW];
    sin_mir    = ph[30] ? (DepthW'(SINE_TABLE_DEPTH) - sin_idx) : sin_idx;
    sin_mag    = (sin_mir >= DepthW'(SINE_TABLE_DEPTH)) ? 17'h10000
                                                        : {1'b0, sine_rom[sin_mir[AddrW-1:0]]};
    case (cfg_i.shape)
      WAVE_SQUARE:   wave = (ph < {cfg_i.duty, 16'h0000}) ? 18'sd65536 : -18'sd65536;
      WAVE_TRIANGLE: wave = tri_wave[17:0];
      WAVE_SINE:     wave = ph[31] ? -$signed({1'b0, sin_mag}) : $signed({1'b0, sin_mag});
      default:       wave = '0;
    endcase
    raw_scaled = {16'h0000, job_i.noise_raw} * {16'h0000, NoiseRecip};
  end

  logic               s1_valid_q;
  logic               s1_silent_q;
  logic signed [17:0] s1_wave_q;
  logic [23:0]        s1_vol_q;
  logic [15:0]        s1_raw_q;
  logic [5:0]         s1_qn_q;

  // ---------------- stage 2: noise value mod 2000, multiplier operand
  logic [16:0]        nv_full;
  logic [10:0]        nv;
  logic signed [17:0] operand;

  always_comb begin
    nv_full = {1'b0, s1_raw_q} - (17'(s1_qn_q) * 17'd2000);
    nv      = (nv_full >= 17'd2000) ? 11'(nv_full - 17'd2000) : nv_full[10:0];
    operand = is_noise ? ($signed({7'b0, nv}) - 18'sd1000) : s1_wave_q;
  end

  logic               s2_valid_q;
  logic               s2_silent_q;
  logic signed [17:0] s2_a_q;
  logic [23:0]        s2_vol_q;

  // ---------------- stage 3: operand (wave or noise value) times volume
  logic signed [42:0] prod;

  assign prod = 43'(s2_a_q * $signed({1'b0, s2_vol_q}));

  logic               s3_valid_q;
  logic               s3_silent_q;
  logic signed [42:0] s3_prod_q;
  logic [7:0]         s3_level_q;

  // ---------------- stage 4: offset, clamp, tone sample or noise scaled sum
  logic signed [42:0] total;
  logic [9:0]         tone_wide;
  logic [7:0]         tone_s;
  logic [18:0]        noise_y;

  always_comb begin
    total     = s3_prod_q + (is_noise ? NoiseOffset : ToneOffset);
    tone_wide = total[42:33];
    tone_s    = (tone_wide > 10'd255) ? 8'd255 : tone_wide[7:0];
    noise_y   = total[34:16];
    if (total[42]) begin
      tone_s  = 8'd0;
      noise_y = '0;
    end
  end

  logic        s4_valid_q;
  logic        s4_silent_q;
  logic [7:0]  s4_tone_q;
  logic [18:0] s4_y_q;
  logic [7:0]  s4_level_q;

  // ---------------- stage 5: quotient estimate of y / 2000
  logic [38:0] y_scaled;

  assign y_scaled = {20'h00000, s4_y_q} * {19'h00000, LevelRecip};

  logic        s5_valid_q;
  logic        s5_silent_q;
  logic [7:0]  s5_tone_q;
  logic [18:0] s5_y_q;
  logic [8:0]  s5_qy_q;
  logic [7:0]  s5_level_q;

  // ---------------- output: quotient correction and final select
  logic [19:0] y_rem;
  logic [9:0]  qf;
  logic [7:0]  noise_s;

  always_comb begin
    y_rem   = {1'b0, s5_y_q} - (20'(s5_qy_q) * 20'd2000);
    qf      = (y_rem >= 20'd2000) ? ({1'b0, s5_qy_q} + 10'd1) : {1'b0, s5_qy_q};
    noise_s = (qf > 10'd255) ? 8'd255 : qf[7:0];
    if (s5_silent_q) begin
      out_sample_d = SilentSample;
      out_level_d  = 8'd0;
    end else begin
      out_sample_d = is_noise ? noise_s : s5_tone_q;
      out_level_d  = s5_level_q;
    end
  end

  // Stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;
      s5_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= job_valid_i;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      s4_valid_q  <= s3_valid_q;
      s5_valid_q  <= s4_valid_q;
      out_valid_q <= s5_valid_q;
    end
  end

  // Stage payload
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_silent_q  <= job_i.silent;
      s1_wave_q    <= wave;
      s1_vol_q     <= job_i.volume;
      s1_raw_q     <= job_i.noise_raw;
      s1_qn_q      <= raw_scaled[31:26];
      s2_silent_q  <= s1_silent_q;
      s2_a_q       <= operand;
      s2_vol_q     <= s1_vol_q;
      s3_silent_q  <= s2_silent_q;
      s3_prod_q    <= prod;
      s3_level_q   <= s2_vol_q[23:16];
      s4_silent_q  <= s3_silent_q;
      s4_tone_q    <= tone_s;
      s4_y_q       <= noise_y;
      s4_level_q   <= s3_level_q;
      s5_silent_q  <= s4_silent_q;
      s5_tone_q    <= s4_tone_q;
      s5_y_q       <= s4_y_q;
      s5_qy_q      <= y_scaled[38:30];
      s5_level_q   <= s4_level_q;
      out_sample_q <= out_sample_d;
      out_level_q  <= out_level_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.sample         = out_sample_q;
  assign out_o.envelope_level = out_level_q;

endmodule

// ===== rtl/core/chiptune_voice_generator.sv =====
// ----------------------------------------------------------------------------
// Chiptune voice generator
// Tone voice with square, triangle, sine and held-noise shapes and a linear
// decay envelope; one unsigned 8-bit sample per input beat.
// ----------------------------------------------------------------------------
// Each input beat (a tick, or a note start followed by its first tick) gives
// exactly one output beat carrying the sample and the envelope level. The
// voice takes one beat per clock cycle while the job queue has room; each
// sample passes the job queue and then the six-register sample pipeline (wave
// lookup, noise reduction, volume multiply, offset and scale, quotient
// correction, output register). The pipeline moves as one and holds while
// the output beat waits; a two-entry job queue between the front end and the
// pipeline keeps input beats flowing until it fills. Configuration registers
// may only be written while no beat is in flight.
module chiptune_voice_generator #(
  parameter int unsigned SINE_TABLE_DEPTH = cvg_pkg::SineTableDepthDefault,
  parameter int unsigned PHASE_BITS       = cvg_pkg::PhaseBitsDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  cvg_in_if.sink                           in_i,
  cvg_out_if.source                        out_o,
  input  logic                             cfg_we_i,
  input  logic [cvg_pkg::CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [cvg_pkg::CfgDataWidth-1:0] cfg_data_i
);
  import cvg_pkg::*;

  cfg_t          cfg_q, cfg_d;
  job_t          front_job, queue_job;
  logic          front_push, queue_ready, queue_valid, back_pop;
  queue_status_t q_stat;

  // Configuration registers
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgWaveShape: cfg_d.shape = wave_shape_e'(cfg_data_i[1:0]);
        CfgDuty:      cfg_d.duty  = cfg_data_i[15:0];
        CfgDecay:     cfg_d.decay = cfg_data_i[23:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.shape <= WAVE_SQUARE;
      cfg_q.duty  <= DutyReset;
      cfg_q.decay <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  cvg_front #(
    .PHASE_BITS (PHASE_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .cfg_i     (cfg_q),
    .q_ready_i (queue_ready),
    .push_o    (front_push),
    .job_o     (front_job)
  );

  cvg_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (front_push),
    .job_i    (front_job),
    .pop_i    (back_pop),
    .job_o    (queue_job),
    .valid_o  (queue_valid),
    .ready_o  (queue_ready),
    .status_o (q_stat)
  );

  cvg_back #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_i       (queue_job),
    .job_valid_i (queue_valid),
    .pop_o       (back_pop),
    .out_o       (out_o)
  );

  // Front never pushes into a full queue
  a_queue_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_stat.push |-> !q_stat.full)
    else $error("job pushed into full queue");

  // Back never pops an empty queue
  a_queue_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_stat.pop |-> !q_stat.empty)
    else $error("job popped from empty queue");

  // Volume below one step cannot move the sample off mid-scale
  a_quiet_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.envelope_level == 8'd0)) |-> (out_o.sample == SilentSample))
    else $error("sample off mid-scale at zero envelope level");

endmodule
